// ----- design/bbp_pkg.sv -----
// Package for the bimodal branch predictor: table sizes, counter constants,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package bbp_pkg;

   localparam int INDEX_BITS_MAX = 12;
   localparam int TABLE_DEPTH    = 1 << INDEX_BITS_MAX;
   localparam int IDX_W          = INDEX_BITS_MAX;
   localparam int CFG_W          = 4;
   localparam int ADDR_W         = 32;
   localparam int COUNT_W        = 32;
   localparam int CTR_W          = 2;

   localparam logic [CTR_W-1:0]   CTR_TOP   = 2'd3;
   localparam logic [CTR_W-1:0]   CTR_RESET = 2'd1;
   localparam logic [CTR_W-1:0]   CTR_ZERO  = 2'd0;
   localparam logic [CFG_W-1:0]   INDEX_BITS_RESET = 4'd12;
   localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic update;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } dp_status_type;

endpackage

// ----- design/bbp_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bbp_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4096,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/bbp_ctrl.sv -----
// Controller for the bimodal branch predictor: table clearing, item accept
// and update sequencing. Depends on bbp_pkg.
module bbp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bbp_pkg::dp_status_type status,
   output bbp_pkg::ctrl_cmd_type  cmd
);
   import bbp_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // The result register must be empty or emptying this cycle.
            if (status.out_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// ----- design/bbp_datapath.sv -----
// Datapath for the bimodal branch predictor: index register, counter table,
// saturating counter update, running totals and the result register.
// Depends on bbp_pkg and bbp_ram.
module bbp_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [bbp_pkg::CFG_W-1:0]    csr_wr_data,
   input  logic [bbp_pkg::ADDR_W-1:0]   req_branch_address,
   input  logic                         req_taken,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_predicted_taken,
   output logic                         rsp_was_correct,
   output logic [bbp_pkg::COUNT_W-1:0]  rsp_branch_total,
   output logic [bbp_pkg::COUNT_W-1:0]  rsp_correct_total,
   input  bbp_pkg::ctrl_cmd_type        cmd,
   output bbp_pkg::dp_status_type       status
);
   import bbp_pkg::*;

   logic [CFG_W-1:0]   index_bits_ff;
   logic [CFG_W-1:0]   width_used;
   logic [IDX_W-1:0]   index_mask;
   logic [IDX_W-1:0]   slot_in;
   logic [IDX_W-1:0]   slot_ff;
   logic               taken_ff;
   logic [IDX_W-1:0]   clear_idx_ff;
   logic [CTR_W-1:0]   ctr_rd;
   logic [CTR_W-1:0]   ctr_in;
   logic               pred;
   logic               ok;
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [CTR_W-1:0]   ram_wr_data;
   logic [COUNT_W-1:0] seen_ff;
   logic [COUNT_W-1:0] hit_ff;
   logic               rsp_valid_ff;
   logic               pred_ff;
   logic               ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff <= INDEX_BITS_RESET;
      end else if (csr_wr_en) begin
         index_bits_ff <= csr_wr_data;
      end
   end

   // An index width of zero acts as one; any width above the maximum acts as the maximum.
   always_comb begin
      if (index_bits_ff == '0) begin
         width_used = CFG_W'(1);
      end else if (int'(index_bits_ff) > INDEX_BITS_MAX) begin
         width_used = CFG_W'(INDEX_BITS_MAX);
      end else begin
         width_used = index_bits_ff;
      end
      for (int i = 0; i < IDX_W; i++) begin
         index_mask[i] = (i < int'(width_used));
      end
   end

   assign slot_in = req_branch_address[IDX_W-1:0] & index_mask;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         slot_ff  <= slot_in;
         taken_ff <= req_taken;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_idx_ff <= '0;
      end else if (cmd.clear_wr) begin
         clear_idx_ff <= clear_idx_ff + 1'b1;
      end
   end

   assign status.clear_last = (clear_idx_ff == '1);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign ram_wr_en   = cmd.clear_wr || cmd.update;
   assign ram_wr_addr = cmd.clear_wr ? clear_idx_ff : slot_ff;
   assign ram_wr_data = cmd.clear_wr ? CTR_RESET : ctr_in;

   bbp_ram #(
      .WIDTH (CTR_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (slot_in),
      .rd_data (ctr_rd)
   );

   // The read data holds until the next accept, so a stalled update still sees it.
   assign pred = ctr_rd[1];
   assign ok   = (pred == taken_ff);

   always_comb begin
      if (taken_ff) begin
         ctr_in = (ctr_rd == CTR_TOP) ? ctr_rd : ctr_rd + 1'b1;
      end else begin
         ctr_in = (ctr_rd == CTR_ZERO) ? ctr_rd : ctr_rd - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         hit_ff  <= '0;
      end else if (cmd.update) begin
         if (seen_ff != COUNT_TOP) begin
            seen_ff <= seen_ff + 1'b1;
         end
         if (ok && hit_ff != COUNT_TOP) begin
            hit_ff <= hit_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.update) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         pred_ff <= pred;
         ok_ff   <= ok;
      end
   end

   // The totals change only on an update, so they double as the result fields.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_taken = pred_ff;
   assign rsp_was_correct     = ok_ff;
   assign rsp_branch_total    = seen_ff;
   assign rsp_correct_total   = hit_ff;

endmodule

// ----- design/bimodal_branch_predictor.sv -----
// Top level of the bimodal branch predictor with 2-bit saturating counters.
// Depends on bbp_pkg, bbp_ctrl, bbp_datapath and bbp_ram.
//
//   Port group   Direction   Carries
//   req_*        in          one resolved branch: address and outcome
//   rsp_*        out         prediction, correctness, branch and correct totals
//   csr_*        in          index width register (write only)
//
// Each item has an accept step, which reads the counter table, and an update
// step, which writes the updated counter back through the table's single write port.
// After reset the table is cleared to weakly not taken, one entry a cycle,
// during which req_stall stays high.
// A stalled result holds the update of the next item, which waits in its
// update step; the next item is still accepted while a result waits.
module bimodal_branch_predictor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [bbp_pkg::CFG_W-1:0]   csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bbp_pkg::ADDR_W-1:0]  req_branch_address,
   input  logic                        req_taken,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_predicted_taken,
   output logic                        rsp_was_correct,
   output logic [bbp_pkg::COUNT_W-1:0] rsp_branch_total,
   output logic [bbp_pkg::COUNT_W-1:0] rsp_correct_total
);
   import bbp_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   bbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bbp_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_branch_address  (req_branch_address),
      .req_taken           (req_taken),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_predicted_taken (rsp_predicted_taken),
      .rsp_was_correct     (rsp_was_correct),
      .rsp_branch_total    (rsp_branch_total),
      .rsp_correct_total   (rsp_correct_total),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

// ----- design/bbp_checker.sv -----
// Port-level checks for the bimodal branch predictor, bound to the top level.
// Depends on bbp_pkg.
module bbp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        csr_wr_en,
   input logic [bbp_pkg::CFG_W-1:0]   csr_wr_data,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [bbp_pkg::ADDR_W-1:0]  req_branch_address,
   input logic                        req_taken,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_predicted_taken,
   input logic                        rsp_was_correct,
   input logic [bbp_pkg::COUNT_W-1:0] rsp_branch_total,
   input logic [bbp_pkg::COUNT_W-1:0] rsp_correct_total
);
   import bbp_pkg::*;

   // A waiting result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_predicted_taken)
         && $stable(rsp_was_correct) && $stable(rsp_branch_total)
         && $stable(rsp_correct_total))
      else $error("result changed while stalled");

   // A result appearing on an empty output comes from an item accepted before its update step.
   a_rsp_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching item");

   // The branch total only ever steps up by one.
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(rsp_branch_total)
         |-> rsp_branch_total == $past(rsp_branch_total) + 1'b1)
      else $error("branch total jumped");

   // The correct total moves only on a correct prediction.
   a_hit_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(rsp_correct_total) |-> rsp_was_correct && rsp_valid)
      else $error("correct total moved without a correct prediction");

   a_hit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_correct_total <= rsp_branch_total)
      else $error("more correct predictions than branches");

endmodule

bind bimodal_branch_predictor bbp_checker u_bbp_checker (.*);

// ----- tb/bimodal_branch_predictor_tb.sv -----
// Self-checking testbench for the bimodal branch predictor: random and directed branches,
// a behavioural predictor of the counter table and totals, and a result scoreboard.
// Depends on bbp_pkg and the bimodal_branch_predictor RTL.
`timescale 1ns / 100ps

module bimodal_branch_predictor_tb;
   import bbp_pkg::*;

   localparam int              CLK_HALF        = 10;
   localparam int              RESET_CYCLES    = 2;
   localparam int              STALL_LIMIT     = 20000;
   localparam int              LONG_HOLD       = 300;
   localparam int              SETTLE_CYCLES   = 20;
   localparam int              REPORT_MAX      = 10;
   localparam logic [CTR_W-1:0] TAKEN_THRESHOLD = 2'd2;

   typedef struct {
      logic [ADDR_W-1:0] addr;
      logic              taken;
   } branch_type;

   typedef struct {
      logic               predicted;
      logic               correct;
      logic [COUNT_W-1:0] branch_total;
      logic [COUNT_W-1:0] correct_total;
   } outcome_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [CFG_W-1:0]    csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ADDR_W-1:0]   req_branch_address = '0;
   logic                req_taken = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_predicted_taken;
   logic                rsp_was_correct;
   logic [COUNT_W-1:0]  rsp_branch_total;
   logic [COUNT_W-1:0]  rsp_correct_total;

   // Predictor state, kept in step with the block at every accepted item.
   logic [CTR_W-1:0]    pattern_counters [TABLE_DEPTH];
   logic [COUNT_W-1:0]  branches_seen;
   logic [COUNT_W-1:0]  correct_seen;
   logic [CFG_W-1:0]    index_width;

   branch_type          branch_queue [$];
   outcome_type         expected_outcomes [$];

   int                  send_idle_pct = 0;
   int                  rsp_idle_pct = 0;
   logic                sender_hold = 1'b0;
   int                  long_holds_asked = 0;
   int                  long_holds_served = 0;
   int                  rsp_hold_left = 0;
   int                  mismatch_count = 0;
   int                  results_checked = 0;
   int                  quiet_cycles = 0;

   bimodal_branch_predictor dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_branch_address  (req_branch_address),
      .req_taken           (req_taken),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_predicted_taken (rsp_predicted_taken),
      .rsp_was_correct     (rsp_was_correct),
      .rsp_branch_total    (rsp_branch_total),
      .rsp_correct_total   (rsp_correct_total)
   );

   always #CLK_HALF clock = ~clock;

   // The prediction is read from the counter before it is moved towards the outcome.
   task automatic predict_branch(input logic [ADDR_W-1:0] addr, input logic tk);
      int unsigned      width;
      int unsigned      slot;
      logic [CTR_W-1:0] ctr;
      outcome_type      want;
      width = index_width;
      if (width < 1) width = 1;
      if (width > INDEX_BITS_MAX) width = INDEX_BITS_MAX;
      slot = addr & ((32'd1 << width) - 32'd1);
      ctr = pattern_counters[slot];
      want.predicted = (ctr >= TAKEN_THRESHOLD);
      want.correct = (want.predicted == tk);
      if (tk && ctr != CTR_TOP) begin
         ctr = ctr + 1'b1;
      end else if (!tk && ctr != CTR_ZERO) begin
         ctr = ctr - 1'b1;
      end
      pattern_counters[slot] = ctr;
      if (branches_seen != COUNT_TOP) branches_seen = branches_seen + 1;
      if (want.correct && correct_seen != COUNT_TOP) correct_seen = correct_seen + 1;
      want.branch_total = branches_seen;
      want.correct_total = correct_seen;
      expected_outcomes.push_back(want);
   endtask

   task automatic note_mismatch(input string what, input logic [COUNT_W-1:0] want,
                                input logic [COUNT_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
         $display("Mismatch on result %0d, %s: expected %h, got %h",
                  results_checked, what, want, got);
      end
   endtask

   // Sender: presents the next pending branch whenever the previous item has gone.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_branch(req_branch_address, req_taken);
         end
         if (!req_valid || !req_stall) begin
            if (branch_queue.size() > 0 && !sender_hold &&
                $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_branch_address <= branch_queue[0].addr;
               req_taken <= branch_queue[0].taken;
               void'(branch_queue.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each accepted result and decides the stall for the next cycle.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_outcomes.size() == 0) begin
               note_mismatch("result with nothing expected", '0, rsp_branch_total);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_predicted_taken !== want.predicted)
                  note_mismatch("predicted_taken", want.predicted, rsp_predicted_taken);
               if (rsp_was_correct !== want.correct)
                  note_mismatch("was_correct", want.correct, rsp_was_correct);
               if (rsp_branch_total !== want.branch_total)
                  note_mismatch("branch_total", want.branch_total, rsp_branch_total);
               if (rsp_correct_total !== want.correct_total)
                  note_mismatch("correct_total", want.correct_total, rsp_correct_total);
            end
         end
         if (long_holds_served != long_holds_asked) begin
            long_holds_served++;
            rsp_hold_left = LONG_HOLD;
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic queue_branch(input logic [ADDR_W-1:0] addr, input logic tk);
      branch_type b;
      b.addr = addr;
      b.taken = tk;
      branch_queue.push_back(b);
   endtask

   // Mostly a few hot branches with their own bias, as loops and ifs would give, plus noise.
   task automatic queue_random_branches(input int n);
      logic [ADDR_W-1:0] hot_addr [8];
      int unsigned       hot_bias [8];
      int                k;
      foreach (hot_addr[i]) begin
         hot_addr[i] = $urandom;
         hot_bias[i] = $urandom_range(100);
      end
      repeat (n) begin
         if ($urandom_range(99) < 80) begin
            k = $urandom_range(7);
            queue_branch(hot_addr[k], $urandom_range(99) < hot_bias[k]);
         end else begin
            queue_branch($urandom, 1'($urandom_range(1)));
         end
      end
   endtask

   task automatic wait_drained();
      while (branch_queue.size() != 0 || req_valid || expected_outcomes.size() != 0)
         @(posedge clock);
   endtask

   // Items still queued stay queued; only the ones already offered must come back.
   task automatic wait_results();
      @(posedge clock);
      while (req_valid || expected_outcomes.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_index_bits(input logic [CFG_W-1:0] value);
      wait_drained();
      // Let the write-back of the last counter finish before the width changes.
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      index_width <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int rsp_pct);
      send_idle_pct <= send_pct;
      rsp_idle_pct <= rsp_pct;
   endtask

   initial begin
      foreach (pattern_counters[i]) pattern_counters[i] = CTR_RESET;
      branches_seen = '0;
      correct_seen = '0;
      index_width = INDEX_BITS_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      set_idling(28, 71);
      write_index_bits(4'd12);
      queue_branch(32'h0000_0000, 1'b0);
      queue_branch(32'hFFFF_FFFF, 1'b1);
      queue_branch(32'h0000_0FFF, 1'b1);
      queue_branch(32'hFFFF_F000, 1'b0);
      queue_branch(32'h0000_1000, 1'b1);
      // Drive one counter up into saturation and back down to zero.
      repeat (4) queue_branch(32'h0000_0005, 1'b1);
      repeat (5) queue_branch(32'h0000_0005, 1'b0);
      queue_branch(32'h0000_0005, 1'b1);
      queue_branch(32'h8000_0000, 1'b1);
      queue_branch(32'h7FFF_FFFF, 1'b0);
      queue_branch(32'hAAAA_AAAA, 1'b1);
      queue_branch(32'h5555_5555, 1'b1);
      queue_branch(32'h5555_5555, 1'b1);

      // A width of zero behaves as one.
      write_index_bits(4'd0);
      queue_branch(32'h0000_0002, 1'b1);
      queue_branch(32'h0000_0003, 1'b0);
      queue_random_branches(180);

      write_index_bits(4'd1);
      queue_random_branches(160);
      wait (branch_queue.size() < 80);
      sender_hold <= 1'b1;
      wait_results();
      sender_hold <= 1'b0;

      set_idling(71, 28);
      write_index_bits(4'd15);
      queue_random_branches(200);
      write_index_bits(4'd4);
      queue_random_branches(200);

      set_idling(0, 0);
      write_index_bits(4'd12);
      long_holds_asked <= long_holds_asked + 1;
      queue_random_branches(250);
      write_index_bits(4'd13);
      queue_random_branches(230);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      mismatch_count += expected_outcomes.size();
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
